// ===== sv/weighted_rgb_patch_ssd_defines.svh =====
// Assertion macros shared by the weighted RGB patch SSD modules.
`ifndef WEIGHTED_RGB_PATCH_SSD_DEFINES_SVH
`define WEIGHTED_RGB_PATCH_SSD_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRPSSD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WRPSSD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wrpssd_pkg.sv =====
// Shared types and constants of the weighted RGB patch SSD block.
package wrpssd_pkg;

    // Field widths.
    localparam int CHAN_W     = 8;
    localparam int WEIGHT_W   = 16;
    localparam int SSQ_W      = 18;
    localparam int TERM_W     = WEIGHT_W + SSQ_W;
    localparam int ACC_W      = 44;
    localparam int RECIP_W    = 31;
    localparam int OUT_W      = 28;

    // Weight fraction bits and the resulting normalization shift.
    localparam int WEIGHT_FRAC_BITS = 12;
    localparam int NORM_SHIFT       = 32 + WEIGHT_FRAC_BITS - 8;

    // Split of the reciprocal into two partial products.
    localparam int RECIP_LO_W = 16;
    localparam int RECIP_HI_W = RECIP_W - RECIP_LO_W;
    localparam int PLO_W      = ACC_W + RECIP_LO_W;
    localparam int PHI_W      = ACC_W + RECIP_HI_W;
    localparam int MID_W      = 61;
    localparam int RES_LSB    = NORM_SHIFT - RECIP_LO_W;

    localparam logic [ACC_W-1:0]   ACC_MAX     = {ACC_W{1'b1}};
    localparam logic [OUT_W-1:0]   OUT_MAX     = {OUT_W{1'b1}};
    localparam logic [RECIP_W-1:0] RECIP_RESET = 31'd1431655765;
    localparam logic [MID_W-1:0]   ROUND_ONE   =
        {{(MID_W-1){1'b0}}, 1'b1} << (NORM_SHIFT - RECIP_LO_W - 1);

    // Depth of the queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;

    // One classified pixel waiting for the multiply-accumulate.
    typedef struct packed {
        logic [SSQ_W-1:0]    ssq;
        logic [WEIGHT_W-1:0] weight;
        logic                last_pixel;
    } wrpssd_entry_t;

endpackage

// ===== sv/wrpssd_front.sv =====
// Front part: accepts pixel pairs and forms the sum of squared channel differences.
module wrpssd_front
    import wrpssd_pkg::*;
(
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CHAN_W-1:0]   s_ref_red,
    input  logic [CHAN_W-1:0]   s_ref_green,
    input  logic [CHAN_W-1:0]   s_ref_blue,
    input  logic [CHAN_W-1:0]   s_cand_red,
    input  logic [CHAN_W-1:0]   s_cand_green,
    input  logic [CHAN_W-1:0]   s_cand_blue,
    input  logic [WEIGHT_W-1:0] s_weight,
    input  logic                s_last_pixel,
    output logic                push_valid,
    input  logic                push_ready,
    output wrpssd_entry_t       push_entry
);

    logic [CHAN_W-1:0]   diff_red;
    logic [CHAN_W-1:0]   diff_green;
    logic [CHAN_W-1:0]   diff_blue;
    logic [2*CHAN_W-1:0] sq_red;
    logic [2*CHAN_W-1:0] sq_green;
    logic [2*CHAN_W-1:0] sq_blue;

    // Absolute channel differences.
    always_comb begin
        diff_red   = (s_ref_red >= s_cand_red) ? (s_ref_red - s_cand_red)
                                               : (s_cand_red - s_ref_red);
        diff_green = (s_ref_green >= s_cand_green) ? (s_ref_green - s_cand_green)
                                                   : (s_cand_green - s_ref_green);
        diff_blue  = (s_ref_blue >= s_cand_blue) ? (s_ref_blue - s_cand_blue)
                                                 : (s_cand_blue - s_ref_blue);
    end

    // Squares and their sum; the result is at most three times 255 squared.
    always_comb begin
        sq_red   = diff_red * diff_red;
        sq_green = diff_green * diff_green;
        sq_blue  = diff_blue * diff_blue;
        push_entry.ssq = SSQ_W'(sq_red) + SSQ_W'(sq_green) + SSQ_W'(sq_blue);
        push_entry.weight     = s_weight;
        push_entry.last_pixel = s_last_pixel;
    end

    // A transaction is taken whenever the queue has room.
    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

// ===== sv/wrpssd_fifo.sv =====
// Small register queue between the front and back parts.
`include "weighted_rgb_patch_ssd_defines.svh"

module wrpssd_fifo
    import wrpssd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  wrpssd_entry_t push_entry,
    output logic          pop_valid,
    input  logic          pop_ready,
    output wrpssd_entry_t pop_entry
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FIFO_DEPTH);

    wrpssd_entry_t    entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `WRPSSD_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL,
        "queue fill count exceeds its depth")
    `WRPSSD_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count did not rise on a lone push")
    `WRPSSD_ASSERT_NEXT(a_count_down, aclk, aresetn, pop && !push,
        count_reg == $past(count_reg) - 1'b1, "queue count did not fall on a lone pop")

endmodule

// ===== sv/wrpssd_back.sv =====
// Back part: weighted multiply-accumulate and normalization of each finished patch.
`include "weighted_rgb_patch_ssd_defines.svh"

module wrpssd_back
    import wrpssd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [RECIP_W-1:0] norm_recip,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  wrpssd_entry_t      pop_entry,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [OUT_W-1:0]   m_mean_loss
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_LO,
        ST_HI,
        ST_OUT
    } state_t;

    state_t            state_reg;
    logic              term_valid_reg;
    logic              term_last_reg;
    logic [TERM_W-1:0] term_reg;
    logic [TERM_W-1:0] term_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  snap_reg;
    logic [PLO_W-1:0]  plo_reg;
    logic [PLO_W-1:0]  plo_next;
    logic [PHI_W-1:0]  phi_reg;
    logic [PHI_W-1:0]  phi_next;
    logic [MID_W-1:0]  mid_next;
    logic [OUT_W-1:0]  loss_next;
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_mean_loss_reg;
    logic              pop_fire;
    logic              out_load;

    // Pop only while accumulating, and not while a patch end is being taken.
    assign pop_ready = (state_reg == ST_RUN) && !(term_valid_reg && term_last_reg);
    assign pop_fire  = pop_ready && pop_valid;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Weighted term, saturating accumulate and the two partial products.
    always_comb begin
        term_next = pop_entry.weight * pop_entry.ssq;
        acc_sum   = {1'b0, acc_reg} + (ACC_W + 1)'(term_reg);
        acc_next  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        plo_next  = snap_reg * norm_recip[RECIP_LO_W-1:0];
        phi_next  = snap_reg * norm_recip[RECIP_W-1:RECIP_LO_W];
    end

    // Round half up at the normalization shift and saturate to the output width.
    always_comb begin
        mid_next = MID_W'(phi_reg) + MID_W'(plo_reg[PLO_W-1:RECIP_LO_W]) + ROUND_ONE;
        if (mid_next[MID_W-1:RES_LSB+OUT_W] != '0) begin
            loss_next = OUT_MAX;
        end else begin
            loss_next = mid_next[RES_LSB+OUT_W-1:RES_LSB];
        end
    end

    // Sequencer, accumulator and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            term_valid_reg <= 1'b0;
            acc_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            term_valid_reg <= pop_fire;
            unique case (state_reg)
                ST_RUN: begin
                    if (term_valid_reg) begin
                        if (term_last_reg) begin
                            snap_reg  <= acc_next;
                            acc_reg   <= '0;
                            state_reg <= ST_LO;
                        end else begin
                            acc_reg <= acc_next;
                        end
                    end
                end
                ST_LO: begin
                    state_reg <= ST_HI;
                end
                ST_HI: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_RUN;
                    end
                end
                default: begin
                    state_reg <= ST_RUN;
                end
            endcase
            if (out_load) begin
                m_valid_reg     <= 1'b1;
                m_mean_loss_reg <= loss_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            term_reg      <= term_next;
            term_last_reg <= pop_entry.last_pixel;
        end
        if (state_reg == ST_LO) begin
            plo_reg <= plo_next;
        end
        if (state_reg == ST_HI) begin
            phi_reg <= phi_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_mean_loss = m_mean_loss_reg;

    `WRPSSD_ASSERT_SAME(a_pop_only_run, aclk, aresetn, pop_fire, state_reg == ST_RUN,
        "queue popped while a patch is being normalized")
    `WRPSSD_ASSERT_NEXT(a_clear_on_last, aclk, aresetn,
        (state_reg == ST_RUN) && term_valid_reg && term_last_reg,
        (acc_reg == '0) && (state_reg == ST_LO), "accumulator not cleared at patch end")
    `WRPSSD_ASSERT_NEXT(a_result_loaded, aclk, aresetn, out_load,
        m_valid_reg && (state_reg == ST_RUN), "patch result not presented after normalization")

endmodule

// ===== sv/weighted_rgb_patch_ssd.sv =====
// Top level of the weighted RGB patch sum-of-squared-differences block.
//
// Usage: the pixel feeder sends one transaction per pixel pair on the s_ channel
// (valid/ready): reference and candidate RGB, an unsigned Q4.12 weight, and a
// last_pixel mark on the final pixel of each patch. Every pixel adds
// weight * (dr^2 + dg^2 + db^2) to a saturating 44-bit accumulator. On a marked
// pixel the block emits one m_ channel transaction holding the mean loss,
// accumulator * norm_reciprocal rounded to 8 fraction bits and saturated to 28
// bits, and clears the accumulator. Unmarked pixels give no result.
// Throughput: one pixel per cycle into a four-entry queue while it has room; the
// back part takes one pixel per cycle while accumulating and stops popping on
// each patch end for the two partial products of the 44 x 31 bit normalization,
// then rounding and the load of the output register.
// On a patch end the result passes the term register, the accumulator snapshot,
// the low and high partial products and the output register, loaded once free.
// cfg_wr_en writes norm_reciprocal at once; write it only while the block is idle.
// Reset (aresetn low, synchronous) empties the queue, clears the accumulator and
// restores norm_reciprocal to 1431655765. When m_ready stays low the result holds
// in m_mean_loss; the next patch end waits, the queue fills and s_ready drops.
module weighted_rgb_patch_ssd
    import wrpssd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [RECIP_W-1:0]  cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CHAN_W-1:0]   s_ref_red,
    input  logic [CHAN_W-1:0]   s_ref_green,
    input  logic [CHAN_W-1:0]   s_ref_blue,
    input  logic [CHAN_W-1:0]   s_cand_red,
    input  logic [CHAN_W-1:0]   s_cand_green,
    input  logic [CHAN_W-1:0]   s_cand_blue,
    input  logic [WEIGHT_W-1:0] s_weight,
    input  logic                s_last_pixel,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OUT_W-1:0]    m_mean_loss
);

    logic [RECIP_W-1:0] norm_recip_reg;
    logic               push_valid;
    logic               push_ready;
    wrpssd_entry_t      push_entry;
    logic               pop_valid;
    logic               pop_ready;
    wrpssd_entry_t      pop_entry;

    // Normalization reciprocal register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_recip_reg <= RECIP_RESET;
        end else if (cfg_wr_en) begin
            norm_recip_reg <= cfg_wr_data;
        end
    end

    // Front part: squared differences per pixel.
    wrpssd_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ref_red    (s_ref_red),
        .s_ref_green  (s_ref_green),
        .s_ref_blue   (s_ref_blue),
        .s_cand_red   (s_cand_red),
        .s_cand_green (s_cand_green),
        .s_cand_blue  (s_cand_blue),
        .s_weight     (s_weight),
        .s_last_pixel (s_last_pixel),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    // Queue decoupling the two parts.
    wrpssd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Back part: accumulation and normalization.
    wrpssd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .norm_recip  (norm_recip_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_entry   (pop_entry),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_mean_loss (m_mean_loss)
    );

endmodule
